FILE: rtl/core/vasc_pkg.sv
// ----------------------------------------------------------------------------
// vasc_pkg
// Shared types and constants for the viewport aspect scaler.
// ----------------------------------------------------------------------------
package vasc_pkg;

    localparam int LINES_W  = 10;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 1;
    localparam int DVSR_W   = LINES_W + 2;

    localparam logic [LINES_W-1:0] LINES_RESET = 10'd256;

    localparam logic [1:0] MODE_FIT     = 2'd0;
    localparam logic [1:0] MODE_INTEGER = 2'd1;
    localparam logic [1:0] MODE_STRETCH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_LINES = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIT,
        S_KH,
        S_KW,
        S_MUL,
        S_DIV3,
        S_PLACE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

FILE: rtl/core/vasc_serial_div.sv
// ----------------------------------------------------------------------------
// vasc_serial_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module vasc_serial_div #(
    parameter int DW = 16,
    parameter int VW = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DW-1:0]        i_dividend,
    input  logic [VW-1:0]        i_divisor,
    output logic [DW-1:0]        o_quotient,
    output vasc_pkg::t_unit_stat o_stat
);
    import vasc_pkg::*;

    localparam int CNT_W = $clog2(DW + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DW-1:0]    r_quo;
    logic [VW-1:0]    r_rem;

    logic [VW:0]      trial;
    logic             ge;
    logic [VW:0]      diff;

    assign trial = {r_rem, r_quo[DW-1]};
    assign ge    = trial >= {1'b0, i_divisor};
    assign diff  = trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], ge};
            r_rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

FILE: rtl/core/vasc_serial_mul.sv
// ----------------------------------------------------------------------------
// vasc_serial_mul
// Shift-add multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module vasc_serial_mul #(
    parameter int AW = 14,
    parameter int BW = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [AW-1:0]        i_a,
    input  logic [BW-1:0]        i_b,
    output logic [AW-1:0]        o_product,
    output vasc_pkg::t_unit_stat o_stat
);
    import vasc_pkg::*;

    localparam int CNT_W = $clog2(BW + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [AW-1:0]    r_a;
    logic [BW-1:0]    r_b;
    logic [AW-1:0]    r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(BW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // product never exceeds AW bits here, so neither does any partial sum
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[AW-2:0], 1'b0} + (r_b[BW-1] ? r_a : '0);
            r_b   <= {r_b[BW-2:0], 1'b0};
        end
    end

    assign o_product   = r_acc;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

FILE: rtl/core/viewport_aspect_scaler_unit.sv
// ----------------------------------------------------------------------------
// viewport_aspect_scaler_unit
// Places a 4:3 display inside a window: fit, integer multiple or stretch.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one window size request.
// Output channel: o_out_valid / i_out_stall carry the placed rectangle.
// Config: i_cfg_we writes register i_cfg_idx (0 scale mode, 1 display lines)
// with i_cfg_data; write only while idle.
// One request at a time. Stretch, and fit where no division is needed,
// go from the fit step straight to placement; a fit with width from
// height adds one divide by 3; integer mode adds at most two divides, a
// multiply and a divide by 3. The work is done by the shared bit-serial
// divider (COORD_BITS + 2 steps per divide) and the 10-step serial
// multiplier for the line multiple.
// The result sits in an output register, so a new request is taken while it
// waits; a stalled receiver only holds the block once the next result is
// ready to be written out.
// Reset (synchronous, active low) returns the sequencer to idle, drops
// o_out_valid and sets scale mode fit and 256 display lines.
// ----------------------------------------------------------------------------
module viewport_aspect_scaler_unit #(
    parameter int COORD_BITS = 14
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [vasc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vasc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [COORD_BITS-1:0]          i_window_width,
    input  logic [COORD_BITS-1:0]          i_window_height,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [COORD_BITS-2:0]          o_left_offset,
    output logic [COORD_BITS-2:0]          o_top_offset,
    output logic [COORD_BITS:0]            o_rect_width,
    output logic [COORD_BITS-1:0]          o_rect_height
);
    import vasc_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int DIV_W = COORD_BITS + 2;

    t_state r_state, n_state;

    logic [1:0]         r_mode;
    logic [LINES_W-1:0] r_lines;
    logic [C-1:0]       r_ww, r_wh, r_h, r_k;
    logic [C:0]         r_w;
    logic               r_wide, r_use_k, r_o_valid;
    logic [C-2:0]       r_left, r_top;
    logic [C:0]         r_ow;
    logic [C-1:0]       r_oh;

    logic [LINES_W-1:0] lines_d;
    logic [C+1:0]       h0_full;
    logic [C-1:0]       h0;
    logic               wide;
    logic [C-1:0]       kmin;
    logic               div_go, mul_go, place_ok;
    logic [DIV_W-1:0]   div_dividend, div_quo;
    logic [DVSR_W-1:0]  div_divisor;
    logic [C-1:0]       mul_prod;
    t_unit_stat         div_stat, mul_stat;
    logic [C:0]         w_c, left_diff;
    logic [C-1:0]       h_c, top_diff;

    assign lines_d = (r_lines == '0) ? LINES_W'(1) : r_lines;
    assign h0_full = {2'b00, r_ww} + {1'b0, r_ww, 1'b0};
    assign h0      = h0_full[C+1:2];
    assign wide    = h0 > r_wh;
    assign kmin    = (div_quo < {2'b00, r_k}) ? div_quo[C-1:0] : r_k;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_FIT;
            r_lines <= LINES_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SCALE_MODE:    r_mode  <= i_cfg_data[1:0];
                REG_DISPLAY_LINES: r_lines <= i_cfg_data[LINES_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_FIT;
            S_FIT: begin
                case (r_mode)
                    MODE_STRETCH: n_state = S_PLACE;
                    MODE_INTEGER: n_state = S_KH;
                    default:      n_state = wide ? S_DIV3 : S_PLACE;
                endcase
            end
            S_KH:    if (div_stat.done) n_state = S_KW;
            S_KW: begin
                if (div_stat.done) begin
                    if (kmin != '0) n_state = S_MUL;
                    else            n_state = r_wide ? S_DIV3 : S_PLACE;
                end
            end
            S_MUL:   if (mul_stat.done) n_state = S_DIV3;
            S_DIV3:  if (div_stat.done) n_state = S_PLACE;
            S_PLACE: if (place_ok) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall = 1'b1;
        div_go     = 1'b0;
        mul_go     = 1'b0;
        place_ok   = 1'b0;
        unique case (r_state) inside
            S_IDLE:             o_in_stall = 1'b0;
            S_KH, S_KW, S_DIV3: div_go = !div_stat.busy && !div_stat.done;
            S_MUL:              mul_go = !mul_stat.busy && !mul_stat.done;
            S_PLACE:            place_ok = !r_o_valid || !i_out_stall;
            default: ;
        endcase
    end

    always_comb begin
        case (r_state)
            S_KH: begin
                div_dividend = {2'b00, r_h};
                div_divisor  = {2'b00, lines_d};
            end
            S_KW: begin
                div_dividend = h0_full + DIV_W'(2);
                div_divisor  = {lines_d, 2'b00};
            end
            default: begin
                div_dividend = r_use_k ? {r_h, 2'b01} : {r_wh, 2'b00};
                div_divisor  = DVSR_W'(3);
            end
        endcase
    end

    vasc_serial_div #(
        .DW(DIV_W),
        .VW(DVSR_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quo),
        .o_stat     (div_stat)
    );

    vasc_serial_mul #(
        .AW(C),
        .BW(LINES_W)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_go),
        .i_a       (r_k),
        .i_b       (lines_d),
        .o_product (mul_prod),
        .o_stat    (mul_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_ww <= (i_window_width  == '0) ? C'(1) : i_window_width;
                    r_wh <= (i_window_height == '0) ? C'(1) : i_window_height;
                end
            end
            S_FIT: begin
                r_use_k <= 1'b0;
                r_wide  <= wide;
                r_w     <= {1'b0, r_ww};
                if (r_mode == MODE_STRETCH) r_h <= r_wh;
                else                        r_h <= wide ? r_wh : h0;
            end
            S_KH:   if (div_stat.done) r_k <= div_quo[C-1:0];
            S_KW:   if (div_stat.done) r_k <= kmin;
            S_MUL: begin
                if (mul_stat.done) begin
                    r_h     <= mul_prod;
                    r_use_k <= 1'b1;
                end
            end
            S_DIV3: if (div_stat.done) r_w <= div_quo[C:0];
            default: ;
        endcase
    end

    // placement and output register
    assign w_c       = (r_w == '0) ? (C+1)'(1) : r_w;
    assign h_c       = (r_h == '0) ? C'(1) : r_h;
    assign left_diff = {1'b0, r_ww} - w_c;
    assign top_diff  = r_wh - h_c;

    always_ff @(posedge i_clk) begin
        if (place_ok) begin
            r_left <= (w_c >= {1'b0, r_ww}) ? '0 : left_diff[C-1:1];
            r_top  <= (h_c >= r_wh) ? '0 : top_diff[C-1:1];
            r_ow   <= w_c;
            r_oh   <= h_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (place_ok) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_left_offset = r_left;
    assign o_top_offset  = r_top;
    assign o_rect_width  = r_ow;
    assign o_rect_height = r_oh;

    a_div_done_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_KH || r_state == S_KW || r_state == S_DIV3))
        else $error("divider finished outside a division step");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(div_stat.busy && mul_stat.busy))
        else $error("divider and multiplier busy together");

    a_valid_from_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == S_PLACE))
        else $error("result raised outside placement");

    a_height_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_rect_height != '0 && o_rect_width != '0))
        else $error("empty rectangle delivered");

endmodule
